>>> rtl/spq_pkg.sv
package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int COUNT_W  = $clog2(CAPACITY + 1);

  localparam int IN_BITS  = 2 + 32 + 32;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = 2 + 4 * 32 + COUNT_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  // requested action
  localparam logic [1:0] ACT_INSERT  = 2'd0;
  localparam logic [1:0] ACT_EXTRACT = 2'd1;
  localparam logic [1:0] ACT_MODIFY  = 2'd2;
  localparam logic [1:0] ACT_NOP     = 2'd3;

  // result status
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  // cell operations
  localparam logic [2:0] OP_HOLD       = 3'd0;
  localparam logic [2:0] OP_INS_BEHIND = 3'd1;
  localparam logic [2:0] OP_INS_AHEAD  = 3'd2;
  localparam logic [2:0] OP_FIND       = 3'd3;
  localparam logic [2:0] OP_SHIFT      = 3'd4;

  typedef struct packed {
    logic signed [31:0] value;
    logic signed [31:0] prio;
  } entry_t;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] key_value;
    logic signed [31:0] key_prio;
  } ctrl_t;

  // ripple flags handed from one cell to the next
  typedef struct packed {
    logic after;   // new entry lands behind this cell
    logic found;   // a matching value sits at or before this cell
    logic drop;    // the matched entry is being removed at or before this cell
  } link_t;

  function automatic logic prio_less(logic signed [31:0] a, logic signed [31:0] b);
    return a < b;
  endfunction

endpackage

>>> rtl/spq_cell.sv
module spq_cell (
  input  logic            clk,
  input  spq_pkg::ctrl_t  ctrl,
  input  logic            occ,
  input  logic            prev_occ,
  input  spq_pkg::entry_t prev_entry,
  input  spq_pkg::link_t  prev_link,
  input  spq_pkg::entry_t next_entry,
  output spq_pkg::entry_t entry,
  output spq_pkg::link_t  link
);

  spq_pkg::entry_t entry_r;
  spq_pkg::entry_t entry_nxt;
  logic            match;
  logic            first;
  logic            dec;
  logic            incr;
  logic            repo;

  always_comb begin
    match = occ && (entry_r.value == ctrl.key_value);
    first = match && !prev_link.found;
    dec   = spq_pkg::prio_less(ctrl.key_prio, entry_r.prio);
    incr  = spq_pkg::prio_less(entry_r.prio, ctrl.key_prio);
    // increase moves the entry only when it now outranks its predecessor
    repo  = dec || (incr && prev_occ && spq_pkg::prio_less(prev_entry.prio, ctrl.key_prio));

    link.found = prev_link.found || match;
    link.drop  = prev_link.drop || (first && repo);
    case (ctrl.op)
      spq_pkg::OP_INS_BEHIND: link.after = occ && !spq_pkg::prio_less(entry_r.prio, ctrl.key_prio);
      spq_pkg::OP_INS_AHEAD:  link.after = occ && dec;
      default:                link.after = 1'b0;
    endcase

    entry_nxt = entry_r;
    case (ctrl.op)
      spq_pkg::OP_INS_BEHIND, spq_pkg::OP_INS_AHEAD: begin
        if (!link.after) begin
          if (prev_link.after) begin
            entry_nxt.value = ctrl.key_value;
            entry_nxt.prio  = ctrl.key_prio;
          end else begin
            entry_nxt = prev_entry;
          end
        end
      end
      spq_pkg::OP_FIND: begin
        if (link.drop) begin
          entry_nxt = next_entry;
        end else if (first && incr) begin
          entry_nxt.prio = ctrl.key_prio;
        end
      end
      spq_pkg::OP_SHIFT: entry_nxt = next_entry;
      default:           entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

>>> rtl/sorted_priority_queue.sv
// Channel  Dir  Handshake             Payload
// in_      in   in_tvalid/in_tready   in_tdata: action, item_value, item_priority
// out_     out  out_tvalid/out_tready out_tdata: status, taken, head, entry_count
//
// Insert, extract, status read and a modify key that moves nothing pass EXEC, then DONE,
// from accept to result; a modify key that moves the entry also passes PLACE (find/remove
// pass, then a re-insert pass through the cells). The row of cells does one ripple pass per
// cycle. in_tready is low from accept until the result is loaded, so no new item is taken
// before the last result is loaded; a result stuck behind a full output register holds the
// next item in the row. rst_n (synchronous) empties the queue.
module sorted_priority_queue (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // [1:0] action, [33:2] item_value, [65:34] item_priority
  input  logic [spq_pkg::IN_W-1:0]   in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // [1:0] status, [33:2] taken_value, [65:34] taken_priority, [97:66] head_value,
  // [129:98] head_priority, then entry_count
  output logic [spq_pkg::OUT_W-1:0]  out_tdata
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_PLACE = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  localparam int CAP = spq_pkg::CAPACITY;
  localparam int CW  = spq_pkg::COUNT_W;

  logic [1:0]          state_r, state_nxt;
  logic [1:0]          act_r;
  logic signed [31:0]  key_value_r;
  logic signed [31:0]  key_prio_r;
  logic [CW-1:0]       count_r, count_nxt;
  logic [1:0]          status_r, status_nxt;
  logic signed [31:0]  taken_value_r, taken_value_nxt;
  logic signed [31:0]  taken_prio_r, taken_prio_nxt;
  logic                out_valid_r;
  logic [spq_pkg::OUT_W-1:0] out_data_r;

  spq_pkg::ctrl_t  ctrl;
  spq_pkg::entry_t cell_entry [CAP];
  spq_pkg::link_t  cell_link  [CAP];
  logic [CAP-1:0]  occ;
  logic            in_fire;
  logic            out_load;
  logic signed [31:0] head_value;
  logic signed [31:0] head_prio;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_tready);

  always_comb begin
    ctrl.key_value = key_value_r;
    ctrl.key_prio  = key_prio_r;
    ctrl.op        = spq_pkg::OP_HOLD;
    if (state_r == S_EXEC) begin
      case (act_r)
        spq_pkg::ACT_INSERT:
          ctrl.op = (count_r < CW'(CAP)) ? spq_pkg::OP_INS_BEHIND : spq_pkg::OP_HOLD;
        spq_pkg::ACT_EXTRACT:
          ctrl.op = (count_r != '0) ? spq_pkg::OP_SHIFT : spq_pkg::OP_HOLD;
        spq_pkg::ACT_MODIFY:
          ctrl.op = (count_r != '0) ? spq_pkg::OP_FIND : spq_pkg::OP_HOLD;
        default:
          ctrl.op = spq_pkg::OP_HOLD;
      endcase
    end else if (state_r == S_PLACE) begin
      ctrl.op = spq_pkg::OP_INS_AHEAD;
    end
  end

  for (genvar k = 0; k < CAP; k++) begin : g_cell
    spq_pkg::entry_t prev_entry;
    spq_pkg::entry_t next_entry;
    spq_pkg::link_t  prev_link;
    logic            prev_occ;

    assign occ[k] = (CW'(k) < count_r);

    if (k == 0) begin : g_head
      assign prev_entry = '0;
      assign prev_occ   = 1'b0;
      // a virtual slot ahead of the head: new entry may land at position 0
      assign prev_link  = '{after: 1'b1, found: 1'b0, drop: 1'b0};
    end else begin : g_body
      assign prev_entry = cell_entry[k-1];
      assign prev_occ   = occ[k-1];
      assign prev_link  = cell_link[k-1];
    end

    if (k == CAP - 1) begin : g_tail
      assign next_entry = '0;
    end else begin : g_mid
      assign next_entry = cell_entry[k+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occ        (occ[k]),
      .prev_occ   (prev_occ),
      .prev_entry (prev_entry),
      .prev_link  (prev_link),
      .next_entry (next_entry),
      .entry      (cell_entry[k]),
      .link       (cell_link[k])
    );
  end

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    status_nxt      = status_r;
    taken_value_nxt = taken_value_r;
    taken_prio_nxt  = taken_prio_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt       = S_EXEC;
          status_nxt      = spq_pkg::ST_OK;
          taken_value_nxt = '0;
          taken_prio_nxt  = '0;
        end
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        case (act_r)
          spq_pkg::ACT_INSERT: begin
            if (count_r < CW'(CAP)) count_nxt = count_r + CW'(1);
            else                    status_nxt = spq_pkg::ST_FULL;
          end
          spq_pkg::ACT_EXTRACT: begin
            if (count_r != '0) begin
              count_nxt       = count_r - CW'(1);
              taken_value_nxt = cell_entry[0].value;
              taken_prio_nxt  = cell_entry[0].prio;
            end else begin
              status_nxt = spq_pkg::ST_EMPTY;
            end
          end
          spq_pkg::ACT_MODIFY: begin
            if (count_r == '0) begin
              status_nxt = spq_pkg::ST_EMPTY;
            end else if (!cell_link[CAP-1].found) begin
              status_nxt = spq_pkg::ST_NOTFOUND;
            end else if (cell_link[CAP-1].drop) begin
              // entry removed this cycle, re-inserted on the next pass
              count_nxt = count_r - CW'(1);
              state_nxt = S_PLACE;
            end
          end
          default: ;
        endcase
      end
      S_PLACE: begin
        count_nxt = count_r + CW'(1);
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign head_value = (count_r == '0) ? -32'sd1 : cell_entry[0].value;
  assign head_prio  = (count_r == '0) ? -32'sd1 : cell_entry[0].prio;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (out_load)        out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    status_r      <= status_nxt;
    taken_value_r <= taken_value_nxt;
    taken_prio_r  <= taken_prio_nxt;
    if (in_fire) begin
      act_r       <= in_tdata[1:0];
      key_value_r <= in_tdata[33:2];
      key_prio_r  <= in_tdata[65:34];
    end
    if (out_load) begin
      out_data_r <= spq_pkg::OUT_W'({count_r, head_prio, head_value,
                                     taken_prio_r, taken_value_r, status_r});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAP))
    else $error("entry count above capacity");

  a_place_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PLACE |-> $past(state_r) == S_EXEC)
    else $error("re-insert pass without a find pass");

  a_place_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PLACE |=> state_r == S_DONE)
    else $error("re-insert pass did not finish");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && status_r == spq_pkg::ST_EMPTY |-> count_r == '0)
    else $error("empty status with entries stored");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && status_r == spq_pkg::ST_FULL |-> count_r == CW'(CAP))
    else $error("full status below capacity");
`endif

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int STALL_LIMIT = 4000;
  localparam int LONG_HOLD   = 300;
  localparam int PHASES      = 11;
  localparam int PHASE_ITEMS = 50;

  typedef struct {
    logic [1:0]                  status;
    logic signed [31:0]          taken_value;
    logic signed [31:0]          taken_prio;
    logic signed [31:0]          head_value;
    logic signed [31:0]          head_prio;
    logic [spq_pkg::COUNT_W-1:0] count;
  } queue_view_t;

  typedef struct {
    logic [1:0]         act;
    logic signed [31:0] value;
    logic signed [31:0] prio;
    bit                 known;
    queue_view_t        want;
  } dir_row_t;

  logic                      clk;
  logic                      rst_n;
  logic                      in_tvalid;
  logic                      in_tready;
  logic [spq_pkg::IN_W-1:0]  in_tdata;
  logic                      out_tvalid;
  logic                      out_tready;
  logic [spq_pkg::OUT_W-1:0] out_tdata;

  bit                 rst_done;
  bit                 calm;
  int                 mismatches;
  int                 views_seen;
  int                 insert_bias;
  queue_view_t        expected_views[$];
  dir_row_t           dir_rows[$];

  // shadow copy of the sorted array, head at index 0
  logic signed [31:0] shadow_value[spq_pkg::CAPACITY];
  logic signed [31:0] shadow_prio[spq_pkg::CAPACITY];
  int                 shadow_count;

  sorted_priority_queue dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic void shadow_remove(int pos);
    for (int k = pos; k + 1 < shadow_count; k++) begin
      shadow_value[k] = shadow_value[k + 1];
      shadow_prio[k]  = shadow_prio[k + 1];
    end
    shadow_count--;
  endfunction

  function automatic void shadow_insert_at(int pos, logic signed [31:0] v,
                                           logic signed [31:0] p);
    for (int k = shadow_count; k > pos; k--) begin
      shadow_value[k] = shadow_value[k - 1];
      shadow_prio[k]  = shadow_prio[k - 1];
    end
    shadow_value[pos] = v;
    shadow_prio[pos]  = p;
    shadow_count++;
  endfunction

  // first slot not outranking p: lands ahead of equals
  function automatic int slot_ahead(logic signed [31:0] p);
    int k;
    k = 0;
    while (k < shadow_count && p < shadow_prio[k]) k++;
    return k;
  endfunction

  // first slot strictly below p: lands behind equals
  function automatic int slot_behind(logic signed [31:0] p);
    int k;
    k = 0;
    while (k < shadow_count && !(shadow_prio[k] < p)) k++;
    return k;
  endfunction

  function automatic logic [1:0] rekey(logic signed [31:0] v, logic signed [31:0] p);
    int                 i;
    logic signed [31:0] old;
    if (shadow_count == 0) return spq_pkg::ST_EMPTY;
    i = 0;
    while (i < shadow_count && shadow_value[i] != v) i++;
    if (i >= shadow_count) return spq_pkg::ST_NOTFOUND;
    old = shadow_prio[i];
    if (p < old) begin
      shadow_remove(i);
      shadow_insert_at(slot_ahead(p), v, p);
    end else if (old < p) begin
      // an increase only jumps equals when it beats the predecessor
      if (i > 0 && shadow_prio[i - 1] < p) begin
        shadow_remove(i);
        shadow_insert_at(slot_ahead(p), v, p);
      end else begin
        shadow_prio[i] = p;
      end
    end
    return spq_pkg::ST_OK;
  endfunction

  function automatic queue_view_t predict_queue_step(logic [1:0] act, logic signed [31:0] v,
                                                     logic signed [31:0] p);
    queue_view_t r;
    r.status      = spq_pkg::ST_OK;
    r.taken_value = '0;
    r.taken_prio  = '0;
    case (act)
      spq_pkg::ACT_INSERT: begin
        if (shadow_count >= spq_pkg::CAPACITY) r.status = spq_pkg::ST_FULL;
        else shadow_insert_at(slot_behind(p), v, p);
      end
      spq_pkg::ACT_EXTRACT: begin
        if (shadow_count == 0) begin
          r.status = spq_pkg::ST_EMPTY;
        end else begin
          r.taken_value = shadow_value[0];
          r.taken_prio  = shadow_prio[0];
          shadow_remove(0);
        end
      end
      spq_pkg::ACT_MODIFY: r.status = rekey(v, p);
      default: ;
    endcase
    r.head_value = (shadow_count == 0) ? -32'sd1 : shadow_value[0];
    r.head_prio  = (shadow_count == 0) ? -32'sd1 : shadow_prio[0];
    r.count      = spq_pkg::COUNT_W'(shadow_count);
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic signed [31:0] rand_prio();
    int r;
    r = $urandom_range(99);
    if (r < 40) return $signed($urandom_range(8)) - 4;
    if (r < 60 && shadow_count > 0) return shadow_prio[$urandom_range(shadow_count - 1)];
    if (r < 70) begin
      case ($urandom_range(3))
        0:       return 32'sh7fff_ffff;
        1:       return 32'sh8000_0000;
        2:       return 32'sd0;
        default: return -32'sd1;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic signed [31:0] rand_value();
    // a small pool gives duplicate values, so modify key must take the first match
    if ($urandom_range(1)) return $signed($urandom_range(7)) - 2;
    return $urandom;
  endfunction

  task automatic offer_item(input logic [1:0] act, input logic signed [31:0] v,
                            input logic signed [31:0] p, input bit known,
                            input queue_view_t want);
    int                       gap;
    logic [spq_pkg::IN_W-1:0] word;
    queue_view_t              got;
    gap  = pick_gap();
    word = '0;
    word[1:0]   = act;
    word[33:2]  = v;
    word[65:34] = p;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    got = predict_queue_step(act, v, p);
    if (known) expected_views.push_back(want);
    else       expected_views.push_back(got);
  endtask

  task automatic send_random();
    logic [1:0]         act;
    logic signed [31:0] v;
    logic signed [31:0] p;
    queue_view_t        none;
    int                 r;
    int                 j;
    r = $urandom_range(99);
    none = '{default: '0};
    if (r < 5) begin
      act = spq_pkg::ACT_NOP;
      v   = $urandom;
      p   = $urandom;
    end else if (r < 30) begin
      act = spq_pkg::ACT_MODIFY;
      if (shadow_count > 0 && $urandom_range(99) < 80) begin
        j = $urandom_range(shadow_count - 1);
        v = shadow_value[j];
        case ($urandom_range(3))
          0:       p = shadow_prio[j];
          1:       p = shadow_prio[j] + ($signed($urandom_range(4)) - 2);
          default: p = rand_prio();
        endcase
      end else begin
        v = rand_value();
        p = rand_prio();
      end
    end else begin
      act = ($urandom_range(99) < insert_bias) ? spq_pkg::ACT_INSERT : spq_pkg::ACT_EXTRACT;
      v   = rand_value();
      p   = rand_prio();
    end
    offer_item(act, v, p, 1'b0, none);
  endtask

  task automatic add_row(input logic [1:0] act, input logic signed [31:0] v,
                         input logic signed [31:0] p);
    dir_row_t row;
    row.act   = act;
    row.value = v;
    row.prio  = p;
    row.known = 1'b0;
    row.want  = '{default: '0};
    dir_rows.push_back(row);
  endtask

  // rows whose result is plain from the row itself; nothing is taken in any of them
  task automatic add_known(input logic [1:0] act, input logic signed [31:0] v,
                           input logic signed [31:0] p, input logic [1:0] st,
                           input logic signed [31:0] hv, input logic signed [31:0] hp,
                           input int cnt);
    dir_row_t row;
    row.act   = act;
    row.value = v;
    row.prio  = p;
    row.known = 1'b1;
    row.want  = '{st, 32'sd0, 32'sd0, hv, hp, spq_pkg::COUNT_W'(cnt)};
    dir_rows.push_back(row);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_view(input logic [spq_pkg::OUT_W-1:0] word);
    queue_view_t want;
    if (expected_views.size() == 0) begin
      $display("%0t: unexpected item, expected none actual %h", $time, word);
      mismatches++;
      return;
    end
    want = expected_views.pop_front();
    check_field("status", 32'(want.status), 32'(word[1:0]));
    check_field("taken_value", want.taken_value, word[33:2]);
    check_field("taken_priority", want.taken_prio, word[65:34]);
    check_field("head_value", want.head_value, word[97:66]);
    check_field("head_priority", want.head_prio, word[129:98]);
    check_field("entry_count", 32'(want.count), 32'(word[130 +: spq_pkg::COUNT_W]));
  endtask

  initial begin : result_sink
    int stall_left;
    bit hold_done;
    bit rdy;
    stall_left = 0;
    hold_done  = 1'b0;
    out_tready <= 1'b0;
    wait (rst_done);
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        check_view(out_tdata);
        views_seen++;
      end
      // one long hold-off so the output register fills and in_tready drops
      if (!hold_done && views_seen >= 200) begin
        hold_done  = 1'b1;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        rdy = 1'b0;
        stall_left--;
      end else begin
        rdy = 1'b1;
        if (!calm && $urandom_range(99) < 20) stall_left = pick_gap();
      end
      out_tready <= rdy;
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    wait (rst_done);
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin : stimulus
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    shadow_count = 0;
    insert_bias  = 50;
    calm         = 1'b1;
    repeat (7) @(posedge clk);
    rst_n    <= 1'b1;
    rst_done = 1'b1;

    add_known(spq_pkg::ACT_NOP, 32'sd0, 32'sd0, spq_pkg::ST_OK, -32'sd1, -32'sd1, 0);
    add_known(spq_pkg::ACT_EXTRACT, 32'sd0, 32'sd0, spq_pkg::ST_EMPTY,
              -32'sd1, -32'sd1, 0);
    add_known(spq_pkg::ACT_MODIFY, 32'sd1, 32'sd1, spq_pkg::ST_EMPTY,
              -32'sd1, -32'sd1, 0);
    add_known(spq_pkg::ACT_INSERT, 32'sh8000_0000, 32'sh7fff_ffff, spq_pkg::ST_OK,
              32'sh8000_0000, 32'sh7fff_ffff, 1);
    add_known(spq_pkg::ACT_INSERT, 32'sh7fff_ffff, 32'sh8000_0000, spq_pkg::ST_OK,
              32'sh8000_0000, 32'sh7fff_ffff, 2);
    add_row(spq_pkg::ACT_INSERT, 32'sd5, 32'sd0);
    add_row(spq_pkg::ACT_INSERT, 32'sd6, 32'sd0);
    add_known(spq_pkg::ACT_MODIFY, 32'sd99, 32'sd3, spq_pkg::ST_NOTFOUND,
              32'sh8000_0000, 32'sh7fff_ffff, 4);
    add_row(spq_pkg::ACT_MODIFY, 32'sd6, 32'sd0);            // same priority, no move
    add_row(spq_pkg::ACT_MODIFY, 32'sd6, 32'sd1);            // increase beats predecessor
    add_row(spq_pkg::ACT_MODIFY, 32'sd5, 32'sd1);            // increase ties predecessor
    add_row(spq_pkg::ACT_MODIFY, 32'sh8000_0000, 32'sd1000); // decrease at head, stays
    add_row(spq_pkg::ACT_MODIFY, 32'sh8000_0000, -32'sd5);   // decrease at head, moves
    for (int k = 0; k < spq_pkg::CAPACITY - 4; k++)
      add_row(spq_pkg::ACT_INSERT, 32'sd100 + k, ((k * 37) % 11) - 5);
    add_row(spq_pkg::ACT_INSERT, -32'sd1, -32'sd1);          // full, dropped
    add_row(spq_pkg::ACT_EXTRACT, 32'sd0, 32'sd0);

    foreach (dir_rows[i])
      offer_item(dir_rows[i].act, dir_rows[i].value, dir_rows[i].prio,
                 dir_rows[i].known, dir_rows[i].want);

    for (int ph = 0; ph < PHASES; ph++) begin
      calm = (ph % 4 == 1);
      case (ph % 3)
        0:       insert_bias = 75;
        1:       insert_bias = 50;
        default: insert_bias = 25;
      endcase
      if (ph == 5) begin
        in_tvalid <= 1'b0;
        while (expected_views.size() != 0) @(posedge clk);
      end
      for (int n = 0; n < PHASE_ITEMS; n++) send_random();
    end

    in_tvalid <= 1'b0;
    calm = 1'b0;
    while (expected_views.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
